// ----- rtl/sdac_pkg.sv -----
// ----------------------------------------------------------------------------
// Signed integer to decimal text: shared definitions
// Types and character constants for the converter.
// ----------------------------------------------------------------------------
package sdac_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned DIGITS   = 10;
    localparam int unsigned BCD_W    = 4 * DIGITS;
    localparam int unsigned BITCNT_W = $clog2(VALUE_W);
    localparam int unsigned IDX_W    = $clog2(DIGITS);

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_LEAD,
        S_EMIT
    } t_state;

endpackage

// ----- rtl/signed_int_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// Signed 32-bit integer to decimal ASCII
// Converts one two's-complement value to its decimal text, most significant
// character first, with a leading minus sign for negative values.
// ----------------------------------------------------------------------------
// A value is taken when start is high and busy is low. The magnitude is
// converted to BCD one bit per cycle by a shift-and-add-three loop; the
// minus sign, if any, is registered from the first step of that loop and
// is on the outputs while the loop still runs. A separate state then finds
// the leading digit, and the digits follow one per cycle. The final
// character is on the outputs during the first idle cycle, in which the
// next value can already be taken. Every character is on the outputs for
// exactly one cycle with o_valid high, and the receiver must take it then;
// o_last_char marks the final character of each number.
module signed_int_to_decimal_ascii
    import sdac_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                     o_valid,
    output logic [CHAR_W-1:0]        o_char_code,
    output logic                     o_last_char
);

    t_state               r_state, n_state;
    logic [VALUE_W-1:0]   r_mag, n_mag;
    logic [BCD_W-1:0]     r_bcd, n_bcd;
    logic [BITCNT_W-1:0]  r_bit_cnt, n_bit_cnt;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic                 r_sign, n_sign;
    logic                 r_valid, n_valid;
    logic [CHAR_W-1:0]    r_char, n_char;
    logic                 r_last, n_last;

    logic [BCD_W-1:0]     adj_bcd;
    logic [IDX_W-1:0]     lead_idx;
    logic [3:0]           cur_digit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_mag     <= n_mag;
        r_bcd     <= n_bcd;
        r_bit_cnt <= n_bit_cnt;
        r_idx     <= n_idx;
        r_sign    <= n_sign;
        r_char    <= n_char;
        r_last    <= n_last;
    end

    always_comb begin
        for (int k = 0; k < DIGITS; k++) begin
            if (r_bcd[4*k +: 4] >= 4'd5) begin
                adj_bcd[4*k +: 4] = r_bcd[4*k +: 4] + 4'd3;
            end else begin
                adj_bcd[4*k +: 4] = r_bcd[4*k +: 4];
            end
        end
    end

    always_comb begin
        lead_idx = '0;
        for (int k = 0; k < DIGITS; k++) begin
            if (r_bcd[4*k +: 4] != 4'd0) begin
                lead_idx = IDX_W'(k);
            end
        end
    end

    assign cur_digit = r_bcd[4*r_idx +: 4];

    always_comb begin
        n_state   = r_state;
        n_mag     = r_mag;
        n_bcd     = r_bcd;
        n_bit_cnt = r_bit_cnt;
        n_idx     = r_idx;
        n_sign    = r_sign;
        n_valid   = 1'b0;
        n_char    = r_char;
        n_last    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_sign    = i_value[VALUE_W-1];
                    n_mag     = i_value[VALUE_W-1] ? (~i_value + 1'b1) : i_value;
                    n_bcd     = '0;
                    n_bit_cnt = '0;
                    n_state   = S_CONV;
                end
            end
            S_CONV: begin
                if (r_sign) begin
                    n_valid = 1'b1;
                    n_char  = CH_MINUS;
                    n_sign  = 1'b0;
                end
                n_bcd     = {adj_bcd[BCD_W-2:0], r_mag[VALUE_W-1]};
                n_mag     = {r_mag[VALUE_W-2:0], 1'b0};
                n_bit_cnt = r_bit_cnt + 1'b1;
                if (r_bit_cnt == BITCNT_W'(VALUE_W - 1)) begin
                    n_state = S_LEAD;
                end
            end
            S_LEAD: begin
                n_idx   = lead_idx;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                n_valid = 1'b1;
                n_char  = CH_ZERO + {4'd0, cur_digit};
                if (r_idx == '0) begin
                    n_last  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_char_code = r_char;
    assign o_last_char = r_last;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after a transfer in");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_char) |-> !busy)
        else $error("still busy when the final character is shown");

    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_char_code == CH_MINUS) |-> (!o_last_char && busy))
        else $error("minus sign marked final or shown while idle");

endmodule

// ----- dv/sdac_text_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal text checker for the signed integer converter
// Watches the input and character channels of the converter, works out the
// expected text for every value it takes, and compares each character that
// comes out, in order, with the oldest one still expected.
// ----------------------------------------------------------------------------
module sdac_text_checker
    import sdac_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      o_valid,
    input  logic [CHAR_W-1:0]         o_char_code,
    input  logic                      o_last_char,
    output int                        o_fail_count,
    output int                        o_pending
);

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_text_char;

    t_text_char expected_text[$];
    int         fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_text.size();

    task automatic report_mismatch(input string what);
        $display("%0t ns: converter text error: %s", $time, what);
        fail_count++;
    endtask

    // Queues the characters of one value, most significant first.
    function automatic void queue_decimal_text(input logic [VALUE_W-1:0] word);
        logic [VALUE_W-1:0] magnitude;
        logic [3:0]         digit_buf[DIGITS];
        int                 digit_count;
        magnitude   = word[VALUE_W-1] ? (~word + 1'b1) : word;
        digit_count = 0;
        do begin
            digit_buf[digit_count] = 4'(magnitude % 10);
            magnitude              = magnitude / 10;
            digit_count++;
        end while (magnitude != 0 && digit_count < DIGITS);
        if (word[VALUE_W-1]) begin
            expected_text.push_back('{code: CH_MINUS, last: 1'b0});
        end
        for (int i = digit_count - 1; i >= 0; i--) begin
            expected_text.push_back('{code: CH_ZERO + CHAR_W'(digit_buf[i]),
                                      last: (i == 0)});
        end
    endfunction

    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (expected_text.size() == 0) begin
                    report_mismatch($sformatf("unexpected character %0d (last %0b)",
                                              o_char_code, o_last_char));
                end else begin
                    want = expected_text.pop_front();
                    if (o_char_code !== want.code) begin
                        report_mismatch($sformatf("char_code %0d, expected %0d",
                                                  o_char_code, want.code));
                    end
                    if (o_last_char !== want.last) begin
                        report_mismatch($sformatf("last_char %0b, expected %0b on char %0d",
                                                  o_last_char, want.last, want.code));
                    end
                end
            end
            if (start && !busy) begin
                queue_decimal_text(i_value);
            end
        end
    end

endmodule

// ----- dv/signed_int_to_decimal_ascii_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the signed integer to decimal ASCII converter
// Sends directed edge values and then random values of every digit count and
// sign, with random pauses, and leaves all checking to the text checker.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_tb;
    import sdac_pkg::*;

    localparam int RANDOM_ITEMS = 410;

    logic                      i_clk   = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start   = 1'b0;
    logic                      busy;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic                      o_valid;
    logic [CHAR_W-1:0]         o_char_code;
    logic                      o_last_char;
    int                        fail_count;
    int                        pending_chars;

    signed_int_to_decimal_ascii i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

    sdac_text_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .o_char_code  (o_char_code),
        .o_last_char  (o_last_char),
        .o_fail_count (fail_count),
        .o_pending    (pending_chars)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Holds a value on the input until the converter takes it.
    task automatic send_value(input logic [VALUE_W-1:0] value);
        start   <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        for (int i = 0; i < cycles; i++) begin
            i_value <= $urandom;
            @(posedge i_clk);
        end
    endtask

    task automatic wait_for_text_drain();
        start <= 1'b0;
        do @(negedge i_clk); while (pending_chars != 0);
        @(posedge i_clk);
    endtask

    // Full-range words, or a magnitude of a chosen digit count with a random sign.
    function automatic logic [VALUE_W-1:0] pick_value();
        longint lo;
        longint hi;
        longint magnitude;
        int     digit_count;
        if ($urandom_range(0, 9) < 3) begin
            return $urandom;
        end
        digit_count = $urandom_range(1, DIGITS);
        lo = 1;
        for (int i = 1; i < digit_count; i++) begin
            lo = lo * 10;
        end
        hi = (digit_count == DIGITS) ? 64'd2147483647 : lo * 10 - 1;
        if (digit_count == 1) begin
            lo = 0;
        end
        magnitude = lo + (longint'({$urandom}) % (hi - lo + 1));
        if ($urandom_range(0, 1) == 1) begin
            magnitude = -magnitude;
        end
        return VALUE_W'(magnitude);
    endfunction

    logic [VALUE_W-1:0] directed_values[] = '{
        32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
        -32'sd999, 32'd12345, 32'd999999999, 32'd1000000000, -32'sd1000000000,
        32'h7FFFFFFF, 32'h80000000, 32'h80000001, 32'h55555555, 32'hAAAAAAAA,
        32'h0000FFFF, 32'hFFFF0000, -32'sd7, 32'd1000000009
    };

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_values[i]) begin
            send_value(directed_values[i]);
        end
        wait_for_text_drain();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            send_value(pick_value());
            if (n == RANDOM_ITEMS / 2) begin
                wait_for_text_drain();
            end else if ((n < 120 || n > 260) && $urandom_range(0, 99) < 6) begin
                pause_sender($urandom_range(1, 60));
            end
        end

        wait_for_text_drain();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("signed_int_to_decimal_ascii: match");
        end else begin
            $display("signed_int_to_decimal_ascii: mismatch");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("signed_int_to_decimal_ascii: mismatch");
        $finish;
    end

endmodule
